// ===== src/tcpq_pkg.sv =====
// Shared types and constants for the two-class priority queue.
// No dependencies; used by tcpq_ctrl, tcpq_datapath and the top level.
package tcpq_pkg;

   localparam int ID_W    = 16;   // id field width on the ports
   localparam int COUNT_W = 5;    // count field width on the ports

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_SERVE    = 2'd1,
      OP_WITHDRAW = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PS_NORMAL    = 2'd0,
      PS_PREFERRED = 2'd1,
      PS_ABSENT    = 2'd2
   } pstat_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] id;
      logic            preferred;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic [ID_W-1:0]    served_id;
      pstat_type          pref_status;
      logic [COUNT_W-1:0] count;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic setup;
      logic move;
      logic ins_write;
      logic finish;
      logic ok;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   scan_end;
      logic   found;
      logic   full;
      logic   move_done;
   } status_type;

endpackage

// ===== src/tcpq_ctrl.sv =====
// Sequencer for the priority queue: scan, shift, write, report.
// Depends on tcpq_pkg; drives tcpq_datapath through cmd_type / status_type.
module tcpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tcpq_pkg::status_type   status,
   output tcpq_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETUP,
      ST_MOVE,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      succ;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // success decided at the end of the id scan
   always_comb begin
      if (status.found) begin
         succ = (status.op != tcpq_pkg::OP_INSERT);
      end else begin
         succ = (status.op == tcpq_pkg::OP_INSERT) && !status.full;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.setup     = (state_ff == ST_SETUP);
      cmd.move      = (state_ff == ST_MOVE);
      cmd.ins_write = (state_ff == ST_WRITE);
      cmd.finish    = (state_ff == ST_DONE) && slot_free;
      cmd.ok        = ok_ff;

      state_in = state_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               ok_in = succ;
               if (!succ || status.op == tcpq_pkg::OP_QUERY) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (status.move_done) begin
               if (status.op == tcpq_pkg::OP_INSERT) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_posts_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not posted or controller not back to idle");

endmodule

// ===== src/tcpq_datapath.sv =====
// Queue storage, id scan, shift engine and result register.
// Depends on tcpq_pkg; controlled by tcpq_ctrl.
module tcpq_datapath #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcpq_pkg::req_word_type   req_word,
   input  tcpq_pkg::cmd_type        cmd,
   output tcpq_pkg::status_type     status,
   output tcpq_pkg::rsp_word_type   rsp_word
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int ENT_W  = ID_BITS + 1;   // {pref, id}

   logic [ENT_W-1:0]   mem [CAPACITY];
   logic [ENT_W-1:0]   rd_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [ENT_W-1:0]   mem_wd;

   tcpq_pkg::op_type   op_ff;
   logic [ID_BITS-1:0] id_ff;
   logic               pref_ff;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   pcnt_ff, pcnt_in;

   logic [CNT_W-1:0]   scan_ptr_ff;
   logic [CNT_W-1:0]   chk_ptr_ff;
   logic               chk_vld_ff, chk_vld_in;

   logic [CNT_W-1:0]   pos_ff;
   logic               hit_pref_ff;
   logic [ID_BITS-1:0] hit_id_ff;

   logic [CNT_W-1:0]   mv_ptr_ff;
   logic [CNT_W-1:0]   mv_adj;
   logic [CNT_W-1:0]   mv_left_ff, mv_left_in;
   logic               up_ff;
   logic               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]  wr_addr_ff;

   logic [CNT_W-1:0]   ins_pos;
   logic               match;
   logic               found;
   logic               last;
   logic               move_step;

   tcpq_pkg::rsp_word_type rsp_ff;

   // serve always hits the head slot
   assign match   = (op_ff == tcpq_pkg::OP_SERVE) || (rd_ff[ID_BITS-1:0] == id_ff);
   assign found   = chk_vld_ff && match;
   assign last    = (chk_ptr_ff == cnt_ff - CNT_W'(1));
   assign ins_pos = pref_ff ? pcnt_ff : cnt_ff;
   assign mv_adj  = up_ff ? (mv_ptr_ff + CNT_W'(1)) : (mv_ptr_ff - CNT_W'(1));
   assign move_step = cmd.move && (mv_left_ff != '0);

   always_comb begin
      status           = '0;
      status.op        = op_ff;
      status.found     = found;
      status.scan_end  = (cnt_ff == '0) || (chk_vld_ff && (match || last));
      status.full      = (cnt_ff == CNT_W'(CAPACITY));
      status.move_done = (mv_left_ff == '0) && !wr_pend_ff;
   end

   // read port: scan or shift source
   assign rd_addr = cmd.move ? mv_ptr_ff[ADDR_W-1:0] : scan_ptr_ff[ADDR_W-1:0];

   // write port: new entry or the shifted word read in the previous cycle
   always_comb begin
      mem_we = cmd.ins_write || wr_pend_ff;
      if (cmd.ins_write) begin
         mem_wa = pos_ff[ADDR_W-1:0];
         mem_wd = {pref_ff, id_ff};
      end else begin
         mem_wa = wr_addr_ff;
         mem_wd = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      cnt_in     = cnt_ff;
      pcnt_in    = pcnt_ff;
      chk_vld_in = cmd.scan && (scan_ptr_ff < cnt_ff);
      mv_left_in = mv_left_ff;
      wr_pend_in = move_step;

      if (cmd.setup) begin
         if (op_ff == tcpq_pkg::OP_INSERT) begin
            mv_left_in = cnt_ff - ins_pos;
         end else begin
            mv_left_in = cnt_ff - pos_ff - CNT_W'(1);
         end
      end else if (move_step) begin
         mv_left_in = mv_left_ff - CNT_W'(1);
      end

      if (cmd.finish && cmd.ok) begin
         unique case (op_ff)
            tcpq_pkg::OP_INSERT: begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pcnt_in = pcnt_ff + CNT_W'(pref_ff);
            end
            tcpq_pkg::OP_SERVE, tcpq_pkg::OP_WITHDRAW: begin
               cnt_in  = cnt_ff - CNT_W'(1);
               pcnt_in = pcnt_ff - CNT_W'(hit_pref_ff);
            end
            tcpq_pkg::OP_QUERY: begin
               cnt_in  = cnt_ff;
            end
            default: begin
               cnt_in  = cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         pcnt_ff    <= '0;
         chk_vld_ff <= 1'b0;
         mv_left_ff <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         pcnt_ff    <= pcnt_in;
         chk_vld_ff <= chk_vld_in;
         mv_left_ff <= mv_left_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_word.op;
         id_ff       <= ID_BITS'(req_word.id);
         pref_ff     <= req_word.preferred;
         scan_ptr_ff <= '0;
      end else if (cmd.scan && scan_ptr_ff < cnt_ff) begin
         scan_ptr_ff <= scan_ptr_ff + CNT_W'(1);
      end

      chk_ptr_ff <= scan_ptr_ff;

      if (cmd.scan && found) begin
         pos_ff      <= chk_ptr_ff;
         hit_pref_ff <= rd_ff[ID_BITS];
         hit_id_ff   <= rd_ff[ID_BITS-1:0];
      end else if (cmd.setup && op_ff == tcpq_pkg::OP_INSERT) begin
         pos_ff      <= ins_pos;
      end

      if (cmd.setup) begin
         if (op_ff == tcpq_pkg::OP_INSERT) begin
            mv_ptr_ff <= cnt_ff - CNT_W'(1);
            up_ff     <= 1'b1;
         end else begin
            mv_ptr_ff <= pos_ff + CNT_W'(1);
            up_ff     <= 1'b0;
         end
      end else if (move_step) begin
         wr_addr_ff <= mv_adj[ADDR_W-1:0];
         mv_ptr_ff  <= up_ff ? (mv_ptr_ff - CNT_W'(1)) : (mv_ptr_ff + CNT_W'(1));
      end

      if (cmd.finish) begin
         rsp_ff.ok    <= cmd.ok;
         rsp_ff.count <= tcpq_pkg::COUNT_W'(cnt_in);
         if (op_ff == tcpq_pkg::OP_SERVE && cmd.ok) begin
            rsp_ff.served_id <= tcpq_pkg::ID_W'(hit_id_ff);
         end else begin
            rsp_ff.served_id <= '0;
         end
         if (op_ff != tcpq_pkg::OP_QUERY) begin
            rsp_ff.pref_status <= tcpq_pkg::PS_NORMAL;
         end else if (!cmd.ok) begin
            rsp_ff.pref_status <= tcpq_pkg::PS_ABSENT;
         end else if (hit_pref_ff) begin
            rsp_ff.pref_status <= tcpq_pkg::PS_PREFERRED;
         end else begin
            rsp_ff.pref_status <= tcpq_pkg::PS_NORMAL;
         end
      end
   end

   assign rsp_word = rsp_ff;

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(CAPACITY)) && (pcnt_ff <= cnt_ff))
      else $error("entry or preferred count out of range");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_write && wr_pend_ff))
      else $error("insert write collides with a pending shift write");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && cmd.ok && op_ff == tcpq_pkg::OP_INSERT)
      |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("successful insert did not bump the count");

endmodule

// ===== src/two_class_priority_queue_unit.sv =====
// A request first scans the entries for its id; a query or a failed request (duplicate insert,
// full queue, absent id) goes straight to its result, while insert, serve and withdraw first
// shift the entries behind the slot (insert then writes the new entry) and post after that.
// Throughput: one word at a time; a new request is taken once the result of the last has posted,
// set by the single-port id scan and the one-slot-per-cycle shift.
// Reset clears the entry counts; the entry memory is left as is and ignored until written.
module two_class_priority_queue_unit #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcpq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcpq_pkg::rsp_word_type rsp_word
);

   tcpq_pkg::cmd_type    cmd;
   tcpq_pkg::status_type status;

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcpq_datapath #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule
